// ----- sv/assf_pkg.sv -----
// Shared types and fixed constants of the adaptive snap smoothing filter.
package assf_pkg;

    localparam int OUT_W      = 12;
    localparam int THR_W      = 12;
    localparam int FS_W       = 13;
    localparam int MULT_W     = 17;
    localparam int DIV_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [MULT_W-1:0] MULT_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MULT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd4;

    typedef struct packed {
        logic start;
    } assf_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } assf_sts_t;

endpackage

// ----- sv/assf_mul.sv -----
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier, MSB first.
module assf_mul #(
    parameter int AW = 34,
    parameter int BW = 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  assf_pkg::assf_ctl_t     ctl,
    input  logic signed [AW-1:0]    a,
    input  logic [BW-1:0]           b,
    output assf_pkg::assf_sts_t     sts,
    output logic signed [AW+BW-1:0] p
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] acc_next;
    logic signed [PW-1:0] addend;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign addend   = b_reg[BW-1] ? PW'(a_reg) : '0;
    assign acc_next = (acc_reg <<< 1) + addend;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            b_reg   <= {b_reg[BW-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (ctl.start) begin
            cnt_reg  <= CW'(BW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign p        = acc_reg;

endmodule

// ----- sv/assf_div.sv -----
// Restoring serial divider, one quotient bit per cycle; remainder starts below divisor.
module assf_div #(
    parameter int QW = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  assf_pkg::assf_ctl_t           ctl,
    input  logic [assf_pkg::DIV_W-1:0]    rem_init,
    input  logic [assf_pkg::DIV_W-1:0]    divisor,
    output assf_pkg::assf_sts_t           sts,
    output logic [QW-1:0]                 q
);

    localparam int RW = assf_pkg::DIV_W;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] div_reg;
    logic [QW-1:0] q_reg;
    logic [RW:0]   rem_shift;
    logic          fits;
    logic [RW-1:0] rem_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign rem_next  = fits ? RW'(rem_shift - {1'b0, div_reg}) : rem_shift[RW-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= rem_init;
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (ctl.start) begin
            cnt_reg  <= CW'(QW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign q        = q_reg;

endmodule

// ----- sv/adaptive_snap_smoothing_filter_unit.sv -----
// Top level of the adaptive snap smoothing filter: control sequencer, state and ports.
// One ADC word in, one filtered word out. Words are handled one at a time; a word
// takes less time when the filter holds in sleep than when it updates. The time per
// word is set by the bit-serial multiplier, which runs up to three passes per word
// (error average, snap scale, level step), and by the serial divider of the snap
// curve. A new word is taken while the previous result still waits at the output
// register. Configuration writes are accepted at any time on the cfg port and must
// only be issued while the filter is idle.
module adaptive_snap_smoothing_filter_unit #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [assf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [assf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_BITS-1:0]            s_raw_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [assf_pkg::OUT_W-1:0]        m_filtered_value,
    output logic                              m_value_changed,
    output logic                              m_is_sleeping,
    output logic [assf_pkg::OUT_W-1:0]        m_raw_echo
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int OW   = assf_pkg::OUT_W;
    localparam int HI_W = (S > assf_pkg::THR_W) ? S : assf_pkg::THR_W;
    localparam int TW   = HI_W + 3;
    localparam int FSW  = HI_W + 2;
    localparam int DW   = TW + F + 1;
    localparam int AW   = DW + 1;
    localparam int BW   = (F > assf_pkg::MULT_W) ? F : assf_pkg::MULT_W;
    localparam int PW   = AW + BW;
    localparam int LW   = S + F;
    localparam int DV   = assf_pkg::DIV_W;

    localparam logic [BW-1:0]  WEIGHT    = BW'(((2 << F) + 2) / 5);
    localparam logic [F:0]     SNAP_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0]     SNAP_HALF = {2'b01, {(F-1){1'b0}}};
    localparam logic [FSW-1:0] FS_CAP    = FSW'(1) << S;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TGT   = 4'd1;
    localparam logic [3:0] ST_EMUL  = 4'd2;
    localparam logic [3:0] ST_EWAIT = 4'd3;
    localparam logic [3:0] ST_SLP   = 4'd4;
    localparam logic [3:0] ST_XMUL  = 4'd5;
    localparam logic [3:0] ST_XWAIT = 4'd6;
    localparam logic [3:0] ST_DWAIT = 4'd7;
    localparam logic [3:0] ST_SNAP  = 4'd8;
    localparam logic [3:0] ST_LMUL  = 4'd9;
    localparam logic [3:0] ST_LWAIT = 4'd10;
    localparam logic [3:0] ST_CLAMP = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg;

    logic                           sleep_en_reg;
    logic                           edge_en_reg;
    logic [assf_pkg::MULT_W-1:0]    mult_reg;
    logic [assf_pkg::THR_W-1:0]     thr_reg;
    logic [assf_pkg::FS_W-1:0]      fs_reg;

    logic [S-1:0]         raw_reg;
    logic signed [DW-1:0] tgtf_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] err_reg;
    logic [LW-1:0]        level_reg;
    logic                 sleep_flag_reg;
    logic                 hold_reg;
    logic [F:0]           snap_reg;
    logic signed [DW:0]   cand_reg;
    logic [OW-1:0]        last_reg;

    logic                 m_valid_reg;
    logic [OW-1:0]        m_value_reg;
    logic                 m_changed_reg;
    logic                 m_sleeping_reg;
    logic [OW-1:0]        m_raw_reg;

    logic [FSW-1:0]       fs_ext;
    logic [FSW-1:0]       fs_eff;
    logic [FSW-1:0]       fs_m1;
    logic signed [TW-1:0] raw_s;
    logic signed [TW-1:0] thr_s;
    logic signed [TW-1:0] fs_s;
    logic signed [TW-1:0] target_next;
    logic signed [DW-1:0] tgtf_next;
    logic signed [DW-1:0] d_next;
    logic [DW-1:0]        mag_e;
    logic [DW-1:0]        mag_d;
    logic [DW-1:0]        thr_f;
    logic                 flag_next;
    logic [assf_pkg::MULT_W-1:0] mult_cl;
    logic [F:0]           snap_adj;
    logic [LW-1:0]        top_l;
    logic signed [DW:0]   top_s;
    logic signed [DW:0]   level_s;
    logic [LW-1:0]        clamp_next;
    logic [OW+S-1:0]      value_ext;
    logic [OW-1:0]        value_out;
    logic [OW+S-1:0]      raw_ext;
    logic                 out_free;

    assf_pkg::assf_ctl_t  mul_ctl;
    assf_pkg::assf_sts_t  mul_sts;
    assf_pkg::assf_ctl_t  div_ctl;
    assf_pkg::assf_sts_t  div_sts;
    logic signed [AW-1:0] mul_a;
    logic [BW-1:0]        mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] p_shift;
    logic                 x_big;
    logic [F-1:0]         div_q;

    // effective full scale and edge push
    assign fs_ext = FSW'(fs_reg);
    assign fs_eff = (fs_ext == '0) ? FSW'(1) : ((fs_ext > FS_CAP) ? FS_CAP : fs_ext);
    assign fs_m1  = fs_eff - 1'b1;
    assign raw_s  = $signed(TW'(raw_reg));
    assign thr_s  = $signed(TW'(thr_reg));
    assign fs_s   = $signed(TW'(fs_eff));

    always_comb begin
        target_next = raw_s;
        if (sleep_en_reg && edge_en_reg) begin
            if (raw_s < thr_s) begin
                target_next = (raw_s <<< 1) - thr_s;
            end else if (raw_s > fs_s - thr_s) begin
                target_next = (raw_s <<< 1) - fs_s + thr_s;
            end
        end
    end

    assign tgtf_next = DW'(target_next) <<< F;
    assign d_next    = tgtf_next - $signed(DW'(level_reg));

    assign mag_e     = err_reg[DW-1] ? DW'(-err_reg) : DW'(err_reg);
    assign mag_d     = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
    assign thr_f     = DW'(thr_reg) << F;
    assign flag_next = sleep_en_reg ? (mag_e < thr_f) : sleep_flag_reg;
    assign mult_cl   = (mult_reg > assf_pkg::MULT_ONE) ? assf_pkg::MULT_ONE : mult_reg;

    assign snap_adj  = sleep_en_reg ? ({1'b0, snap_reg[F:1]} + SNAP_HALF) : snap_reg;

    assign top_l     = {fs_m1[S-1:0], {F{1'b0}}};
    assign top_s     = $signed((DW+1)'(top_l));
    assign level_s   = $signed((DW+1)'(level_reg));
    assign clamp_next = cand_reg[DW] ? '0 : ((cand_reg > top_s) ? top_l : cand_reg[LW-1:0]);

    assign value_ext = {{OW{1'b0}}, level_reg[LW-1:F]};
    assign value_out = value_ext[OW-1:0];
    assign raw_ext   = {{OW{1'b0}}, raw_reg};

    // shared serial arithmetic
    always_comb begin
        case (state_reg)
            ST_EMUL: begin
                mul_a = AW'(d_reg) - AW'(err_reg);
                mul_b = WEIGHT;
            end
            ST_XMUL: begin
                mul_a = $signed(AW'(mag_d[DW-1:F]));
                mul_b = BW'(mult_cl);
            end
            default: begin
                mul_a = AW'(d_reg);
                mul_b = BW'(snap_reg[F-1:0]);
            end
        endcase
    end

    assign mul_ctl.start = (state_reg == ST_EMUL) || (state_reg == ST_XMUL) ||
                           (state_reg == ST_LMUL);
    assign p_shift       = mul_p >>> F;
    assign x_big         = |mul_p[PW-1:DV-1];
    assign div_ctl.start = (state_reg == ST_XWAIT) && mul_sts.done && !x_big;

    assf_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .sts     (mul_sts),
        .p       (mul_p)
    );

    assf_div #(
        .QW (F)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .rem_init ({mul_p[DV-2:0], 1'b0}),
        .divisor  ({1'b1, mul_p[DV-2:0]}),
        .sts      (div_sts),
        .q        (div_q)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_en_reg <= 1'b0;
            edge_en_reg  <= 1'b1;
            mult_reg     <= '0;
            thr_reg      <= assf_pkg::THR_W'(25);
            fs_reg       <= assf_pkg::FS_W'(4096);
        end else if (cfg_valid) begin
            case (cfg_index)
                assf_pkg::CFG_SLEEP_EN:   sleep_en_reg <= cfg_data[0];
                assf_pkg::CFG_EDGE_EN:    edge_en_reg  <= cfg_data[0];
                assf_pkg::CFG_SNAP_MULT:  mult_reg     <= cfg_data[assf_pkg::MULT_W-1:0];
                assf_pkg::CFG_THRESHOLD:  thr_reg      <= cfg_data[assf_pkg::THR_W-1:0];
                assf_pkg::CFG_FULL_SCALE: fs_reg       <= cfg_data[assf_pkg::FS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            err_reg        <= '0;
            level_reg      <= '0;
            sleep_flag_reg <= 1'b0;
            last_reg       <= '0;
            hold_reg       <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        raw_reg   <= s_raw_sample;
                        state_reg <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    tgtf_reg  <= tgtf_next;
                    d_reg     <= d_next;
                    state_reg <= ST_EMUL;
                end
                ST_EMUL: begin
                    state_reg <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (mul_sts.done) begin
                        err_reg   <= err_reg + p_shift[DW-1:0];
                        state_reg <= ST_SLP;
                    end
                end
                ST_SLP: begin
                    sleep_flag_reg <= flag_next;
                    hold_reg       <= sleep_en_reg && flag_next;
                    state_reg      <= (sleep_en_reg && flag_next) ? ST_OUT : ST_XMUL;
                end
                ST_XMUL: begin
                    state_reg <= ST_XWAIT;
                end
                ST_XWAIT: begin
                    if (mul_sts.done) begin
                        if (x_big) begin
                            snap_reg  <= SNAP_ONE;
                            state_reg <= ST_SNAP;
                        end else begin
                            state_reg <= ST_DWAIT;
                        end
                    end
                end
                ST_DWAIT: begin
                    if (div_sts.done) begin
                        snap_reg  <= {1'b0, div_q};
                        state_reg <= ST_SNAP;
                    end
                end
                ST_SNAP: begin
                    if (snap_adj[F]) begin
                        cand_reg  <= (DW+1)'(tgtf_reg);
                        state_reg <= ST_CLAMP;
                    end else begin
                        snap_reg  <= snap_adj;
                        state_reg <= ST_LMUL;
                    end
                end
                ST_LMUL: begin
                    state_reg <= ST_LWAIT;
                end
                ST_LWAIT: begin
                    if (mul_sts.done) begin
                        cand_reg  <= level_s + (DW+1)'($signed(p_shift[DW-1:0]));
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    level_reg <= clamp_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        last_reg  <= value_out;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_value_reg    <= value_out;
            m_changed_reg  <= (value_out != last_reg);
            m_sleeping_reg <= hold_reg;
            m_raw_reg      <= raw_ext[OW-1:0];
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_value_reg;
    assign m_value_changed  = m_changed_reg;
    assign m_is_sleeping    = m_sleeping_reg;
    assign m_raw_echo       = m_raw_reg;

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input word accepted while another is in flight");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_ctl.start |-> !mul_sts.busy)
        else $error("multiplier started while busy");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.start |-> (!div_sts.busy && !mul_sts.busy))
        else $error("divider started while arithmetic busy");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

endmodule

// ----- test/adaptive_snap_smoothing_filter_unit_tb.sv -----
// Testbench of the adaptive snap smoothing filter: bit-true scoreboard, drivers and checks.

typedef struct {
    logic [assf_pkg::OUT_W-1:0] level;
    logic                       changed;
    logic                       sleeping;
    logic [assf_pkg::OUT_W-1:0] raw;
} filter_word_t;

class assf_scoreboard;
    localparam int     SAMPLE_W = 12;
    localparam int     FRAC_W   = 16;
    localparam longint ONE_Q    = 64'sd1 << FRAC_W;
    localparam longint WEIGHT_Q = ((64'sd2 << FRAC_W) + 2) / 5;

    bit                              sleep_en;
    bit                              edge_en;
    logic [assf_pkg::MULT_W-1:0]     snap_mult;
    logic [assf_pkg::THR_W-1:0]      threshold;
    logic [assf_pkg::FS_W-1:0]       full_scale;

    logic [27:0]                     level_q;
    logic signed [30:0]              err_avg_q;
    bit                              asleep;
    logic [assf_pkg::OUT_W-1:0]      last_level;

    filter_word_t                    due_words[$];
    int                              errors;

    function new();
        sleep_en   = 1'b0;
        edge_en    = 1'b1;
        snap_mult  = '0;
        threshold  = 12'd25;
        full_scale = 13'd4096;
        level_q    = '0;
        err_avg_q  = '0;
        asleep     = 1'b0;
        last_level = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [assf_pkg::CFG_IDX_W-1:0] idx,
                          logic [assf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            assf_pkg::CFG_SLEEP_EN:   sleep_en   = data[0];
            assf_pkg::CFG_EDGE_EN:    edge_en    = data[0];
            assf_pkg::CFG_SNAP_MULT:  snap_mult  = data[assf_pkg::MULT_W-1:0];
            assf_pkg::CFG_THRESHOLD:  threshold  = data[assf_pkg::THR_W-1:0];
            assf_pkg::CFG_FULL_SCALE: full_scale = data[assf_pkg::FS_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
        longint       r, thr, fs, tgt, d, ea, lv, mag, m, x, snap, nxt, top;
        bit           hold;
        filter_word_t w;
        r   = raw;
        thr = threshold;
        fs  = full_scale;
        lv  = level_q;
        ea  = err_avg_q;
        if (fs < 1) fs = 1;
        if (fs > (longint'(1) << SAMPLE_W)) fs = longint'(1) << SAMPLE_W;

        tgt = r;
        if (sleep_en && edge_en) begin
            if (r < thr) tgt = 2 * r - thr;
            else if (r > fs - thr) tgt = 2 * r - fs + thr;
        end

        d  = tgt * ONE_Q - lv;
        ea = ea + (((d - ea) * WEIGHT_Q) >>> FRAC_W);

        if (sleep_en) begin
            mag    = ea < 0 ? -ea : ea;
            asleep = mag < thr * ONE_Q;
        end
        hold = sleep_en && asleep;

        if (!hold) begin
            mag = d < 0 ? -d : d;
            m   = snap_mult > assf_pkg::MULT_ONE ? assf_pkg::MULT_ONE : snap_mult;
            x   = (mag >>> FRAC_W) * m;
            if (x >= longint'(assf_pkg::MULT_ONE)) snap = ONE_Q;
            else snap = (2 * x * ONE_Q) / (x + longint'(assf_pkg::MULT_ONE));
            if (sleep_en) snap = (snap >>> 1) + (ONE_Q >>> 1);
            if (snap >= ONE_Q) nxt = tgt * ONE_Q;
            else nxt = lv + ((d * snap) >>> FRAC_W);
            top = (fs - 1) * ONE_Q;
            if (nxt < 0) nxt = 0;
            else if (nxt > top) nxt = top;
            lv = nxt;
        end

        level_q   = 28'(lv);
        err_avg_q = 31'(ea);

        w.level    = 12'(lv >>> FRAC_W);
        w.changed  = w.level != last_level;
        w.sleeping = hold;
        w.raw      = raw;
        last_level = w.level;
        due_words.push_back(w);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_output(logic [assf_pkg::OUT_W-1:0] level, logic changed, logic sleeping,
                      logic [assf_pkg::OUT_W-1:0] raw);
        filter_word_t want;
        if (due_words.size() == 0) begin
            report($sformatf("unexpected word level=%0d raw=%0d", level, raw));
            return;
        end
        want = due_words.pop_front();
        if (level !== want.level)
            report($sformatf("raw %0d: level %0d, want %0d", want.raw, level, want.level));
        if (changed !== want.changed)
            report($sformatf("raw %0d: changed %b, want %b", want.raw, changed, want.changed));
        if (sleeping !== want.sleeping)
            report($sformatf("raw %0d: sleeping %b, want %b", want.raw, sleeping,
                             want.sleeping));
        if (raw !== want.raw)
            report($sformatf("raw echo %0d, want %0d", raw, want.raw));
    endtask
endclass

module adaptive_snap_smoothing_filter_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 1500;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [assf_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [assf_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic [11:0]                       s_raw_sample;
    logic                              m_valid;
    logic                              m_ready;
    logic [assf_pkg::OUT_W-1:0]        m_filtered_value;
    logic                              m_value_changed;
    logic                              m_is_sleeping;
    logic [assf_pkg::OUT_W-1:0]        m_raw_echo;

    assf_scoreboard sb = new();
    bit             rx_hold_req;
    bit             rx_quiet;
    int             base_level;
    int             idle_cycles;

    adaptive_snap_smoothing_filter_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_sample     (s_raw_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_value_changed  (m_value_changed),
        .m_is_sleeping    (m_is_sleeping),
        .m_raw_echo       (m_raw_echo)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_output(m_filtered_value, m_value_changed, m_is_sleeping, m_raw_echo);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("adaptive_snap_smoothing_filter_unit_tb: done, errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request, none when quiet
    initial begin : rx_side
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(logic [11:0] raw);
        s_valid      <= 1'b1;
        s_raw_sample <= raw;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.take_sample(raw);
    endtask

    task automatic cfg_write(logic [assf_pkg::CFG_IDX_W-1:0] idx,
                             logic [assf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.due_words.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_settings(bit sl, bit ed, logic [16:0] mu, logic [11:0] th,
                                  logic [12:0] fs);
        drain();
        repeat (4) @(posedge aclk);
        cfg_write(assf_pkg::CFG_SLEEP_EN,   17'(sl));
        cfg_write(assf_pkg::CFG_EDGE_EN,    17'(ed));
        cfg_write(assf_pkg::CFG_SNAP_MULT,  mu);
        cfg_write(assf_pkg::CFG_THRESHOLD,  17'(th));
        cfg_write(assf_pkg::CFG_FULL_SCALE, 17'(fs));
        cfg_valid <= 1'b0;
    endtask

    // steady level with noise, occasional jumps, drift and near-edge runs
    task automatic send_run(int count, int spread, bit gaps);
        int v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 11))
                0: base_level = $urandom_range(0, 4095);
                1: base_level = $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                     : $urandom_range(4055, 4095);
                2: base_level = base_level + int'($urandom_range(0, 200)) - 100;
                default: ;
            endcase
            if (base_level < 0) base_level = 0;
            else if (base_level > 4095) base_level = 4095;
            if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 4095);
            else
                v = base_level + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            else if (v > 4095) v = 4095;
            send_sample(12'(v));
            if (gaps && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
        end
    endtask

    initial begin : stimulus
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_raw_sample <= '0;
        base_level   = 2048;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero multiplier, level never moves
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);

        apply_settings(1'b0, 1'b1, assf_pkg::MULT_ONE, 12'd25, 13'd4096);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);

        // multiplier above one acts as one
        apply_settings(1'b0, 1'b1, 17'h1FFFF, 12'd25, 13'd4096);
        send_sample(12'd2000);
        send_sample(12'd100);

        apply_settings(1'b0, 1'b0, 17'd300, 12'd25, 13'd4096);
        send_sample(12'd3000);
        send_sample(12'd3100);

        // edge push at both ends
        apply_settings(1'b1, 1'b1, assf_pkg::MULT_ONE, 12'd25, 13'd4096);
        send_sample(12'd0);
        send_sample(12'd10);
        send_sample(12'd24);
        send_sample(12'd25);
        send_sample(12'd4070);
        send_sample(12'd4071);
        send_sample(12'd4095);

        // zero full scale acts as one, threshold above it: low edge wins
        apply_settings(1'b1, 1'b1, assf_pkg::MULT_ONE, 12'd4095, 13'd0);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2000);

        // sleep hold, then sleep off keeps the flag but does not hold
        apply_settings(1'b1, 1'b0, assf_pkg::MULT_ONE, 12'd4095, 13'd4096);
        send_sample(12'd100);
        send_sample(12'd100);
        apply_settings(1'b0, 1'b0, assf_pkg::MULT_ONE, 12'd4095, 13'd4096);
        send_sample(12'd100);

        apply_settings(1'b0, 1'b1, assf_pkg::MULT_ONE, 12'd25, 13'd4096);
        send_run(55, 20, 1'b1);

        apply_settings(1'b1, 1'b1, assf_pkg::MULT_ONE, 12'd25, 13'd4096);
        send_run(55, 10, 1'b1);

        // output held off while input keeps coming
        apply_settings(1'b1, 1'b1, 17'd8000, 12'd25, 13'd4096);
        rx_hold_req = 1'b1;
        send_run(55, 6, 1'b0);

        apply_settings(1'b0, 1'b0, 17'd300, 12'd0, 13'd4096);
        send_run(35, 30, 1'b1);
        drain();
        send_run(20, 30, 1'b1);

        apply_settings(1'b1, 1'b0, 17'd1000, 12'd4095, 13'd4096);
        send_run(55, 40, 1'b1);

        apply_settings(1'b1, 1'b1, 17'd20000, 12'd100, 13'd1000);
        send_run(55, 50, 1'b1);

        apply_settings(1'b0, 1'b1, 17'd0, 12'd25, 13'd4096);
        send_run(55, 20, 1'b1);

        apply_settings(1'b1, 1'b1, 17'h1FFFF, 12'd50, 13'h1FFF);
        send_run(55, 15, 1'b1);

        apply_settings(1'b1, 1'b1, 17'd500, 12'd3000, 13'd0);
        send_run(55, 10, 1'b1);

        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       17'($urandom_range(0, 131071)), 12'($urandom_range(0, 4095)),
                       13'($urandom_range(0, 8191)));
        send_run(55, 25, 1'b1);

        apply_settings(1'b0, 1'b0, 17'd65535, 12'd12, 13'd2);
        send_run(55, 25, 1'b1);

        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       17'($urandom_range(0, 131071)), 12'($urandom_range(0, 200)),
                       13'($urandom_range(1, 4096)));
        send_run(55, 8, 1'b1);

        // closing stretch at full rate
        apply_settings(1'b1, 1'b1, 17'd4000, 12'd30, 13'd4096);
        rx_quiet = 1'b1;
        send_run(55, 3, 1'b0);

        drain();
        repeat (100) @(posedge aclk);
        if (sb.due_words.size() != 0) sb.report("expected word never came");
        if (sb.errors == 0) begin
            $display("adaptive_snap_smoothing_filter_unit_tb: done, clean");
        end else begin
            $display("adaptive_snap_smoothing_filter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
